// ===== rtl/core/wsfs_pkg.sv =====
`default_nettype none

package wsfs_pkg;

   // layout limits
   localparam int unsigned NumSpecs = 7;
   localparam logic [2:0] MaxFields = 3'd7;
   localparam logic [7:0] SpecVariable = 8'd255;

   // register indexes on the csr port
   localparam logic [2:0] CsrFieldCount = 3'd0;
   localparam logic [2:0] CsrSpecZero = 3'd1;
   localparam logic [2:0] CsrSpecOne = 3'd2;
   localparam logic [2:0] CsrSpecTwo = 3'd3;
   localparam logic [2:0] CsrSpecThree = 3'd4;
   localparam logic [2:0] CsrSpecFour = 3'd5;
   localparam logic [2:0] CsrSpecFive = 3'd6;
   localparam logic [2:0] CsrSpecSix = 3'd7;

   typedef enum logic [1:0] {
      PhSkip = 2'd0,
      PhField = 2'd1,
      PhSep = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      StOk = 2'd0,
      StMissing = 2'd1,
      StBad = 2'd2,
      StExcess = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic       in_field;
      logic [2:0] field_number;
      logic       field_closed;
      logic       message_end;
      logic [1:0] status;
   } rsp_type;

   // layout held in the csr block
   typedef struct packed {
      logic [2:0]                    field_count;
      logic [NumSpecs-1:0][7:0]      spec;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/core/whitespace_field_splitter.sv =====
`default_nettype none

// Splits a byte stream message into fields against a layout held in csr
// registers (field count and seven field lengths, 255 meaning a field that
// runs to the next whitespace) and reports, on the last byte, ok, missing,
// bad or excess arguments. One request is taken every clock cycle while
// req_stall is low, and each produces one response: an input register feeds
// a combinational parser step with registered message state, and an output
// register holds the response, so a stalled response still lets the next
// request into the input register while that register is empty. Csr writes
// are always ready and should be made while no message bytes are in flight.
module whitespace_field_splitter (
   input  wire logic              clock,
   input  wire logic              reset,
   // requests
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire wsfs_pkg::req_type req_data,
   // responses
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output wsfs_pkg::rsp_type      rsp_data,
   // csr writes
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [7:0]        csr_data
);

   logic                 req_valid_ff, req_valid_in;
   wsfs_pkg::req_type    req_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   wsfs_pkg::rsp_type    rsp_data_ff, rsp_data_in;
   wsfs_pkg::cfg_type    cfg;
   logic                 req_accept;
   logic                 advance;

   assign csr_ready = 1'b1;

   wsfs_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // handshake between the two registers
   assign advance = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign req_valid_in = req_accept || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_data_ff <= req_data;
      end
   end

   wsfs_parser u_parser (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .fire  (advance),
      .req   (req_data_ff),
      .rsp   (rsp_data_in)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // a processed request always lands in the output register
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed request lost");

   // a held request stays in the input register
   assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff && $stable(req_data_ff))
      else $error("held request dropped");

   // status is only reported with the message end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.message_end |-> (rsp_data_ff.status == wsfs_pkg::StOk))
      else $error("status without message end");

   // field number is zero when no field is touched
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.in_field && !rsp_data_ff.field_closed
         |-> (rsp_data_ff.field_number == 3'd0))
      else $error("stray field number");

endmodule

`default_nettype wire

// ===== rtl/core/wsfs_csr.sv =====
`default_nettype none

module wsfs_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [2:0]        wr_index,
   input  wire logic [7:0]        wr_data,
   output wsfs_pkg::cfg_type      cfg
);

   logic [2:0]                          field_count_ff;
   logic [wsfs_pkg::NumSpecs-1:0][7:0]  spec_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         field_count_ff <= 3'd0;
         for (int i = 0; i < wsfs_pkg::NumSpecs; i++) begin
            spec_ff[i] <= wsfs_pkg::SpecVariable;
         end
      end else if (wr_en) begin
         unique case (wr_index)
            wsfs_pkg::CsrFieldCount: field_count_ff <= wr_data[2:0];
            wsfs_pkg::CsrSpecZero:   spec_ff[0] <= wr_data;
            wsfs_pkg::CsrSpecOne:    spec_ff[1] <= wr_data;
            wsfs_pkg::CsrSpecTwo:    spec_ff[2] <= wr_data;
            wsfs_pkg::CsrSpecThree:  spec_ff[3] <= wr_data;
            wsfs_pkg::CsrSpecFour:   spec_ff[4] <= wr_data;
            wsfs_pkg::CsrSpecFive:   spec_ff[5] <= wr_data;
            wsfs_pkg::CsrSpecSix:    spec_ff[6] <= wr_data;
            default: ;
         endcase
      end
   end

   assign cfg.field_count = field_count_ff;
   assign cfg.spec = spec_ff;

endmodule

`default_nettype wire

// ===== rtl/core/wsfs_parser.sv =====
`default_nettype none

module wsfs_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire wsfs_pkg::cfg_type cfg,
   input  wire logic              fire,
   input  wire wsfs_pkg::req_type req,
   output wsfs_pkg::rsp_type      rsp
);

   wsfs_pkg::phase_type  phase_ff, phase_in;
   logic [2:0]           field_ff, field_in;
   logic [7:0]           bytes_ff, bytes_in;
   wsfs_pkg::status_type err_code_ff, err_code_in;
   logic                 err_seen_ff, err_seen_in;

   function automatic logic [7:0] spec_of(input logic [2:0] k, input wsfs_pkg::cfg_type c);
      logic [7:0] s;
      if (k == 3'd7) begin
         s = wsfs_pkg::SpecVariable;
      end else begin
         s = c.spec[k];
      end
      return s;
   endfunction

   function automatic logic is_ws(input logic [7:0] b);
      return ((b >= 8'h09) && (b <= 8'h0D)) || (b == 8'h20);
   endfunction

   // byte step and end-of-message check
   always_comb begin
      logic                 ws;
      logic [2:0]           cnt;
      logic [7:0]           spec_cur;
      logic [7:0]           spec_end;
      logic [7:0]           bytes_inc;
      logic                 more_left;
      wsfs_pkg::phase_type  nxt_phase;
      logic [2:0]           nxt_field;
      logic [7:0]           nxt_bytes;
      wsfs_pkg::status_type nxt_code;
      logic                 nxt_seen;

      ws = is_ws(req.data_byte);
      cnt = (cfg.field_count > wsfs_pkg::MaxFields) ? wsfs_pkg::MaxFields : cfg.field_count;
      spec_cur = spec_of(field_ff, cfg);
      bytes_inc = (bytes_ff == 8'd255) ? 8'd255 : bytes_ff + 8'd1;
      nxt_phase = phase_ff;
      nxt_field = field_ff;
      nxt_bytes = bytes_ff;
      nxt_code = err_code_ff;
      nxt_seen = err_seen_ff;

      rsp.in_field = 1'b0;
      rsp.field_number = 3'd0;
      rsp.field_closed = 1'b0;
      rsp.message_end = req.last_byte;
      rsp.status = wsfs_pkg::StOk;

      // per-byte field tracking
      if (!err_seen_ff) begin
         unique case (phase_ff)
            wsfs_pkg::PhSkip: begin
               if (!ws) begin
                  if (field_ff >= cnt) begin
                     nxt_code = wsfs_pkg::StExcess;
                     nxt_seen = 1'b1;
                  end else if (spec_cur == 8'd0) begin
                     nxt_code = wsfs_pkg::StBad;
                     nxt_seen = 1'b1;
                  end else begin
                     rsp.in_field = 1'b1;
                     rsp.field_number = field_ff;
                     nxt_bytes = 8'd1;
                     nxt_phase = (spec_cur == 8'd1) ? wsfs_pkg::PhSep : wsfs_pkg::PhField;
                  end
               end
            end
            wsfs_pkg::PhField: begin
               if ((spec_cur == wsfs_pkg::SpecVariable) && ws) begin
                  rsp.field_closed = 1'b1;
                  rsp.field_number = field_ff;
                  nxt_field = (field_ff == 3'd7) ? field_ff : field_ff + 3'd1;
                  nxt_bytes = 8'd0;
                  nxt_phase = wsfs_pkg::PhSkip;
               end else begin
                  rsp.in_field = 1'b1;
                  rsp.field_number = field_ff;
                  nxt_bytes = bytes_inc;
                  if ((spec_cur != wsfs_pkg::SpecVariable) && (bytes_inc >= spec_cur)) begin
                     nxt_phase = wsfs_pkg::PhSep;
                  end
               end
            end
            wsfs_pkg::PhSep: begin
               if (ws) begin
                  rsp.field_closed = 1'b1;
                  rsp.field_number = field_ff;
                  nxt_field = (field_ff == 3'd7) ? field_ff : field_ff + 3'd1;
                  nxt_bytes = 8'd0;
                  nxt_phase = wsfs_pkg::PhSkip;
               end else begin
                  nxt_code = wsfs_pkg::StBad;
                  nxt_seen = 1'b1;
               end
            end
            default: ;
         endcase
      end

      // status on the last byte
      spec_end = spec_of(nxt_field, cfg);
      more_left = ({1'b0, nxt_field} + 4'd1) < {1'b0, cnt};
      if (req.last_byte) begin
         if (nxt_seen) begin
            rsp.status = nxt_code;
         end else if (nxt_phase == wsfs_pkg::PhField) begin
            if (spec_end == wsfs_pkg::SpecVariable) begin
               rsp.field_closed = 1'b1;
               rsp.field_number = nxt_field;
               rsp.status = more_left ? wsfs_pkg::StMissing : wsfs_pkg::StOk;
            end else begin
               rsp.status = wsfs_pkg::StMissing;
            end
         end else if (nxt_phase == wsfs_pkg::PhSep) begin
            rsp.field_closed = 1'b1;
            rsp.field_number = nxt_field;
            rsp.status = more_left ? wsfs_pkg::StMissing : wsfs_pkg::StOk;
         end else if (nxt_field >= cnt) begin
            rsp.status = wsfs_pkg::StOk;
         end else if ((spec_end == 8'd0) && !more_left) begin
            // empty final field closed by the message end
            if (!rsp.field_closed) begin
               rsp.field_closed = 1'b1;
               rsp.field_number = nxt_field;
            end
            rsp.status = wsfs_pkg::StOk;
         end else begin
            rsp.status = wsfs_pkg::StMissing;
         end
      end

      // message state clears after the last byte
      if (req.last_byte) begin
         phase_in = wsfs_pkg::PhSkip;
         field_in = 3'd0;
         bytes_in = 8'd0;
         err_code_in = wsfs_pkg::StOk;
         err_seen_in = 1'b0;
      end else begin
         phase_in = nxt_phase;
         field_in = nxt_field;
         bytes_in = nxt_bytes;
         err_code_in = nxt_code;
         err_seen_in = nxt_seen;
      end
   end

   // message state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wsfs_pkg::PhSkip;
         field_ff <= 3'd0;
         bytes_ff <= 8'd0;
         err_code_ff <= wsfs_pkg::StOk;
         err_seen_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         field_ff <= field_in;
         bytes_ff <= bytes_in;
         err_code_ff <= err_code_in;
         err_seen_ff <= err_seen_in;
      end
   end

   // a processed last byte leaves a clean message state
   assert property (@(posedge clock) disable iff (reset)
      fire && req.last_byte |=> (phase_ff == wsfs_pkg::PhSkip) && (field_ff == 3'd0)
                                && !err_seen_ff)
      else $error("message state not cleared after last byte");

   // the error code is only held together with the error flag
   assert property (@(posedge clock) disable iff (reset)
      !err_seen_ff |-> (err_code_ff == wsfs_pkg::StOk))
      else $error("error code set without error flag");

   // once an error is latched no field activity is reported
   assert property (@(posedge clock) disable iff (reset)
      fire && err_seen_ff |-> !rsp.in_field && !rsp.field_closed)
      else $error("field activity after error");

endmodule

`default_nettype wire

// ===== verif/tb_whitespace_field_splitter.sv =====
`default_nettype none

module tb_whitespace_field_splitter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 500000;
   localparam int RandomLayouts = 12;
   localparam int BytesPerLayout = 135;

   // response stall styles
   localparam int StallNone = 0;
   localparam int StallSparse = 1;
   localparam int StallLong = 2;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   wsfs_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   wsfs_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [7:0]        csr_data = '0;

   whitespace_field_splitter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // layout copy and parser state of the splitter
   wsfs_pkg::cfg_type     layout;
   wsfs_pkg::phase_type   parse_phase = wsfs_pkg::PhSkip;
   logic [2:0]            cur_field = '0;
   logic [7:0]            field_bytes = '0;
   wsfs_pkg::status_type  err_code = wsfs_pkg::StOk;
   logic                  err_seen = 1'b0;

   wsfs_pkg::req_type     byte_backlog_q[$];
   wsfs_pkg::rsp_type     predicted_rsp_q[$];
   logic [7:0]            message_buf[$];

   int          error_count = 0;
   int          requests_sent = 0;
   int          messages_seen = 0;
   int          layouts_used = 0;
   int          status_seen[4] = '{default: 0};
   int          cycle_count = 0;

   function automatic logic is_blank(logic [7:0] b);
      return (b >= 8'h09 && b <= 8'h0D) || b == 8'h20;
   endfunction

   function automatic logic [7:0] field_spec(int k);
      return (k >= wsfs_pkg::NumSpecs) ? wsfs_pkg::SpecVariable : layout.spec[k];
   endfunction

   function automatic void latch_error(wsfs_pkg::status_type code);
      err_code = code;
      err_seen = 1'b1;
   endfunction

   function automatic void advance_field();
      if (cur_field != 3'd7)
         cur_field++;
      field_bytes = '0;
      parse_phase = wsfs_pkg::PhSkip;
   endfunction

   // next response of the splitter for one request byte
   function automatic wsfs_pkg::rsp_type split_byte(wsfs_pkg::req_type r);
      wsfs_pkg::rsp_type o;
      logic              blank;
      int                cnt;
      int                cf;
      logic [7:0]        s;
      o = '0;
      blank = is_blank(r.data_byte);
      cnt = int'(layout.field_count);
      cf = int'(cur_field);
      if (!err_seen) begin
         case (parse_phase)
            wsfs_pkg::PhSkip: begin
               if (!blank) begin
                  if (cf >= cnt) begin
                     latch_error(wsfs_pkg::StExcess);
                  end else begin
                     s = field_spec(cf);
                     if (s == 8'd0) begin
                        latch_error(wsfs_pkg::StBad);
                     end else begin
                        o.in_field = 1'b1;
                        o.field_number = 3'(cf);
                        field_bytes = 8'd1;
                        parse_phase = (s != wsfs_pkg::SpecVariable && s <= 8'd1)
                                      ? wsfs_pkg::PhSep : wsfs_pkg::PhField;
                     end
                  end
               end
            end
            wsfs_pkg::PhField: begin
               s = field_spec(cf);
               if (s == wsfs_pkg::SpecVariable && blank) begin
                  o.field_closed = 1'b1;
                  o.field_number = 3'(cf);
                  advance_field();
               end else begin
                  o.in_field = 1'b1;
                  o.field_number = 3'(cf);
                  if (field_bytes != 8'd255)
                     field_bytes++;
                  if (s != wsfs_pkg::SpecVariable && field_bytes >= s)
                     parse_phase = wsfs_pkg::PhSep;
               end
            end
            default: begin
               if (blank) begin
                  o.field_closed = 1'b1;
                  o.field_number = 3'(cf);
                  advance_field();
               end else begin
                  latch_error(wsfs_pkg::StBad);
               end
            end
         endcase
      end

      // status on the last byte, then back to the start of a message
      if (r.last_byte) begin
         o.message_end = 1'b1;
         if (err_seen) begin
            o.status = err_code;
         end else begin
            cf = int'(cur_field);
            if (parse_phase == wsfs_pkg::PhField
                && field_spec(cf) != wsfs_pkg::SpecVariable) begin
               o.status = wsfs_pkg::StMissing;
            end else if (parse_phase != wsfs_pkg::PhSkip) begin
               o.field_closed = 1'b1;
               o.field_number = 3'(cf);
               o.status = (cf + 1 < cnt) ? wsfs_pkg::StMissing : wsfs_pkg::StOk;
            end else if (cf >= cnt) begin
               o.status = wsfs_pkg::StOk;
            end else if (field_spec(cf) == 8'd0 && cf + 1 >= cnt) begin
               // empty final field closes at the end of the message
               if (!o.field_closed) begin
                  o.field_closed = 1'b1;
                  o.field_number = 3'(cf);
               end
               o.status = wsfs_pkg::StOk;
            end else begin
               o.status = wsfs_pkg::StMissing;
            end
         end
         parse_phase = wsfs_pkg::PhSkip;
         cur_field = '0;
         field_bytes = '0;
         err_code = wsfs_pkg::StOk;
         err_seen = 1'b0;
      end
      return o;
   endfunction

   function automatic void log_error(string msg);
      if (error_count < 10)
         $display("%0t ns: %s", $time, msg);
      error_count++;
   endfunction

   // request driver: bursts of random length separated by random gaps
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin : drive_requests
      wsfs_pkg::rsp_type predicted;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted = split_byte(req_data);
            predicted_rsp_q.insert(predicted_rsp_q.size(), predicted);
            requests_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || byte_backlog_q.size() == 0) begin
               if (gap_left > 0)
                  gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_data <= byte_backlog_q.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 48);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
   end

   // response checker with its own stall pattern
   int stall_style = StallNone;
   int style_left = 0;
   int hold_left = 0;

   always @(posedge clock) begin : check_responses
      wsfs_pkg::rsp_type want;
      logic              stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp_q.size() == 0) begin
               log_error($sformatf("response with none pending: %p", rsp_data));
            end else begin
               want = predicted_rsp_q.pop_front();
               if (rsp_data.in_field !== want.in_field
                   || rsp_data.field_number !== want.field_number
                   || rsp_data.field_closed !== want.field_closed
                   || rsp_data.message_end !== want.message_end
                   || rsp_data.status !== want.status)
                  log_error($sformatf({"mismatch: expected in_field %0d field_number %0d ",
                     "field_closed %0d message_end %0d status %0d, got %0d %0d %0d %0d %0d"},
                     want.in_field, want.field_number, want.field_closed,
                     want.message_end, want.status, rsp_data.in_field,
                     rsp_data.field_number, rsp_data.field_closed,
                     rsp_data.message_end, rsp_data.status));
               if (want.message_end) begin
                  messages_seen++;
                  status_seen[want.status]++;
               end
            end
         end

         if (style_left == 0) begin
            stall_style = $urandom_range(StallNone, StallLong);
            style_left = $urandom_range(50, 300);
         end else begin
            style_left--;
         end
         case (stall_style)
            StallNone: stall_next = 1'b0;
            StallSparse: stall_next = ($urandom_range(0, 99) < 30);
            default: begin
               if (hold_left > 0) begin
                  hold_left--;
                  stall_next = rsp_stall;
               end else begin
                  stall_next = !rsp_stall;
                  hold_left = rsp_stall ? $urandom_range(0, 6) : $urandom_range(0, 12);
               end
            end
         endcase
         rsp_stall <= stall_next;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles, %0d responses pending",
                  cycle_count, predicted_rsp_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // nothing queued, nothing on the wire, nothing owed
   task automatic wait_idle();
      do
         @(negedge clock);
      while (byte_backlog_q.size() != 0 || req_valid || predicted_rsp_q.size() != 0);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == wsfs_pkg::CsrFieldCount)
         layout.field_count = value[2:0];
      else
         layout.spec[idx - wsfs_pkg::CsrSpecZero] = value;
   endtask

   function automatic void add_byte(logic [7:0] b);
      message_buf.insert(message_buf.size(), b);
   endfunction

   function automatic void flush_message(bit ends_message);
      wsfs_pkg::req_type item;
      foreach (message_buf[i]) begin
         item.data_byte = message_buf[i];
         item.last_byte = ends_message && (i == message_buf.size() - 1);
         byte_backlog_q.insert(byte_backlog_q.size(), item);
      end
      message_buf.delete();
   endfunction

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(0, 5))
         0: return 8'h09;
         1: return 8'h0A;
         2: return 8'h0B;
         3: return 8'h0C;
         4: return 8'h0D;
         default: return 8'h20;
      endcase
   endfunction

   function automatic logic [7:0] solid_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (is_blank(b));
      return b;
   endfunction

   // mostly well-formed messages for the current layout, some broken, some noise
   task automatic build_random_message();
      int         kind;
      int         nf;
      int         len;
      logic [7:0] s;
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
         len = $urandom_range(1, 12);
         repeat (len)
            add_byte(($urandom_range(0, 2) == 0) ? blank_byte()
                                                 : 8'($urandom_range(0, 255)));
      end else begin
         nf = int'(layout.field_count);
         if (kind == 1 && nf > 0)
            nf--;
         else if (kind == 2)
            nf++;
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
            add_byte(blank_byte());
         for (int k = 0; k < nf; k++) begin
            if (k > 0)
               repeat ($urandom_range(1, 3))
                  add_byte(blank_byte());
            s = field_spec(k);
            if (s == wsfs_pkg::SpecVariable)
               len = ($urandom_range(0, 40) == 0) ? $urandom_range(250, 300)
                                                  : $urandom_range(1, 6);
            else
               len = int'(s);
            // field one byte short or long
            if (kind == 3 && $urandom_range(0, 1) == 0)
               len = len + (($urandom_range(0, 1) == 0) ? -1 : 1);
            for (int i = 0; i < len; i++) begin
               if (i == 0 || s == wsfs_pkg::SpecVariable)
                  add_byte(solid_byte());
               else
                  add_byte(($urandom_range(0, 3) == 0) ? blank_byte()
                                                       : 8'($urandom_range(0, 255)));
            end
         end
         if (kind == 4 && message_buf.size() > 0)
            message_buf[$urandom_range(0, message_buf.size() - 1)] = 8'($urandom_range(0, 255));
         repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 2) : 0)
            add_byte(blank_byte());
         if (message_buf.size() == 0)
            add_byte(blank_byte());
      end
   endtask

   task automatic pick_layout(int layout_no);
      logic [2:0] count;
      logic [7:0] spec_val;
      int         r;
      count = 3'($urandom_range(0, 7));
      if (layout_no == 0)
         count = wsfs_pkg::MaxFields;
      else if (layout_no == 1)
         count = 3'd0;
      else if (layout_no == 2)
         count = 3'd2;
      write_csr(wsfs_pkg::CsrFieldCount, 8'(count));
      for (int k = 0; k < wsfs_pkg::NumSpecs; k++) begin
         r = $urandom_range(0, 19);
         if (r < 2)
            spec_val = 8'd0;
         else if (r < 9)
            spec_val = wsfs_pkg::SpecVariable;
         else if (r < 16)
            spec_val = 8'($urandom_range(1, 3));
         else
            spec_val = 8'($urandom_range(4, 12));
         // longest fixed field
         if (layout_no == 2 && k == 0)
            spec_val = 8'd254;
         write_csr(wsfs_pkg::CsrSpecZero + 3'(k), spec_val);
      end
      layouts_used++;
   endtask

   initial begin
      int layout_bytes;
      layout.field_count = '0;
      layout.spec = {wsfs_pkg::NumSpecs{wsfs_pkg::SpecVariable}};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // fixed, variable and empty final field
      write_csr(wsfs_pkg::CsrFieldCount, 8'd3);
      write_csr(wsfs_pkg::CsrSpecZero, 8'd2);
      write_csr(wsfs_pkg::CsrSpecOne, wsfs_pkg::SpecVariable);
      write_csr(wsfs_pkg::CsrSpecTwo, 8'd0);
      layouts_used++;
      @(negedge clock);
      // two fields close on the last byte
      message_buf = '{8'h09, 8'h20, 8'h41, 8'h00, 8'h0D, 8'h78, 8'h79, 8'h0C};
      flush_message(1'b1);
      // fixed field too long, rest ignored
      message_buf = '{8'h41, 8'h42, 8'h43, 8'h20, 8'h5A};
      flush_message(1'b1);
      // fixed field cut short by the end
      message_buf = '{8'h51};
      flush_message(1'b1);
      // byte where the empty field would begin
      message_buf = '{8'hFF, 8'h80, 8'h0A, 8'h76, 8'h20, 8'h7F};
      flush_message(1'b1);
      wait_idle();

      // layout changed in the middle of a message
      write_csr(wsfs_pkg::CsrFieldCount, 8'd1);
      write_csr(wsfs_pkg::CsrSpecZero, wsfs_pkg::SpecVariable);
      layouts_used++;
      @(negedge clock);
      message_buf = '{8'h08, 8'h0E, 8'h21};
      flush_message(1'b0);
      wait_idle();
      write_csr(wsfs_pkg::CsrSpecZero, 8'd1);
      @(negedge clock);
      message_buf = '{8'h1F, 8'h0D};
      flush_message(1'b1);
      wait_idle();

      // no fields expected
      write_csr(wsfs_pkg::CsrFieldCount, 8'd0);
      layouts_used++;
      @(negedge clock);
      message_buf = '{8'h20, 8'h0D};
      flush_message(1'b1);
      message_buf = '{8'h55};
      flush_message(1'b1);
      wait_idle();

      // random layouts, each with a run of random messages
      for (int n = 0; n < RandomLayouts; n++) begin
         pick_layout(n);
         @(negedge clock);
         layout_bytes = 0;
         while (layout_bytes < BytesPerLayout) begin
            build_random_message();
            layout_bytes += message_buf.size();
            flush_message(1'b1);
         end
         wait_idle();
      end

      repeat (10) @(posedge clock);
      $display("checked %0d requests in %0d messages over %0d layouts",
               requests_sent, messages_seen, layouts_used);
      $display("status ok %0d, missing %0d, bad %0d, excess %0d; %0d errors",
               status_seen[wsfs_pkg::StOk], status_seen[wsfs_pkg::StMissing],
               status_seen[wsfs_pkg::StBad], status_seen[wsfs_pkg::StExcess], error_count);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
